>>> rtl/core/gradient_noise_2d_eval_assert.svh
// assertion macros for the gradient noise block
// expects clk and rst_n in the scope of each use
`ifndef GRADIENT_NOISE_2D_EVAL_ASSERT_SVH
`define GRADIENT_NOISE_2D_EVAL_ASSERT_SVH

// same-cycle implication
`define GN2D_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GN2D_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/gn2d_pkg.sv
// shared types and constants for the gradient noise block
// no dependencies
package gn2d_pkg;

  localparam int GRID_SIDE = 64;
  localparam int FRAC_BITS = 16;
  localparam int POS_W     = FRAC_BITS + 1;
  localparam int GRAD_W    = 16;
  localparam int CFG_W     = 7;
  localparam int OFF_W     = FRAC_BITS + 2;
  localparam int TT_W      = 2 * POS_W;
  localparam int Q_W       = 2 * FRAC_BITS + 4;
  localparam int Q1_W      = Q_W - FRAC_BITS;
  localparam int FADE_W    = POS_W + Q1_W - FRAC_BITS;
  localparam int WGT_W     = 2 * FADE_W - FRAC_BITS;
  localparam int DOT_W     = GRAD_W + OFF_W + 1 - 14;
  localparam int PROD_W    = WGT_W + 1 + DOT_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int IN_DATA_W = 80;
  localparam int OUT_DATA_W = 24;

  localparam logic [POS_W-1:0] ONE_Q = POS_W'(1) << FRAC_BITS;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_EVAL  = 1'b1;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef logic [POS_W-1:0]         pos_t;
  typedef logic [FADE_W-1:0]        fade_t;
  typedef logic signed [DOT_W-1:0]  dot_t;

endpackage

>>> rtl/core/gn2d_ram.sv
// generic single-write, single-read ram with registered read
// no dependencies
module gn2d_ram #(
  parameter int W = 32,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata_r
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/gn2d_fade.sv
// four-stage quintic fade 6t^5-15t^4+10t^3 in q.16, round half up
// depends on gn2d_pkg
module gn2d_fade import gn2d_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  pos_t  t_i,
  output fade_t f_o
);

  localparam logic [Q_W-1:0] HALF = Q_W'(1) << (FRAC_BITS - 1);

  pos_t             a_t_r, b_t_r, b_t2_r, c_t3_r;
  logic [TT_W-1:0]  a_tt_r;
  logic [Q1_W-1:0]  b_q1_r, c_q1_r;
  fade_t            f_r;

  pos_t             t2_nxt, t3_nxt;
  logic [Q1_W-1:0]  q1_nxt;
  fade_t            f_nxt;
  logic [Q_W-1:0]   q;
  logic [TT_W-1:0]  p3;
  logic [Q_W:0]     p5;

  always_comb begin
    t2_nxt = POS_W'((Q_W'(a_tt_r) + HALF) >> FRAC_BITS);
    q = Q_W'(6) * Q_W'(a_tt_r) + (Q_W'(10) << (2 * FRAC_BITS))
        - ((Q_W'(15) * Q_W'(a_t_r)) << FRAC_BITS);
    q1_nxt = Q1_W'((q + HALF) >> FRAC_BITS);
    p3 = TT_W'(b_t2_r) * TT_W'(b_t_r);
    t3_nxt = POS_W'((Q_W'(p3) + HALF) >> FRAC_BITS);
    p5 = (Q_W+1)'(c_t3_r) * (Q_W+1)'(c_q1_r);
    f_nxt = FADE_W'((p5 + (Q_W+1)'(HALF)) >> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_t_r  <= t_i;
      a_tt_r <= TT_W'(t_i) * TT_W'(t_i);
      b_t_r  <= a_t_r;
      b_t2_r <= t2_nxt;
      b_q1_r <= q1_nxt;
      c_t3_r <= t3_nxt;
      c_q1_r <= b_q1_r;
      f_r    <= f_nxt;
    end
  end

  assign f_o = f_r;

endmodule

>>> rtl/core/gradient_noise_2d_eval.sv
// 2d gradient noise evaluator: top level, nine-stage pipeline
// depends on gn2d_pkg, gn2d_ram, gn2d_fade, gradient_noise_2d_eval_assert.svh
//
// channel   dir  handshake            payload
// in_       in   in_tvalid/in_tready  tuser kind, tdata gradient write or point
// out_      out  out_tvalid/out_tready tdata noise_value
// cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one transaction per cycle while in_tready is high; after reset the gradient table is
// cleared, one entry a cycle, over all GRID_SIDE*GRID_SIDE (4096) entries with
// in_tready low; cfg writes are taken throughout.
// the whole pipeline advances together whenever the output register is free or drained;
// four table copies give the four corner reads of each point, all in the same cycle.
module gradient_noise_2d_eval import gn2d_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [5:0] grad_col, [11:6] grad_row, [27:12] grad_x, [43:28] grad_y,
  // [60:44] pos_x, [77:61] pos_y
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,   // kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [16:0] noise_value
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

`include "gradient_noise_2d_eval_assert.svh"

  localparam int DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(GRID_SIDE);
  localparam int SW    = POS_W + CFG_W;

  // config
  logic [CFG_W-1:0] grid_width_r, grid_height_r;
  logic [CFG_W-1:0] eff_w, eff_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= 7'd64;
      grid_height_r <= 7'd64;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        REG_GRID_HEIGHT: grid_height_r <= cfg_data;
        default: ;
      endcase
    end
  end
  assign cfg_ready = 1'b1;

  function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] r);
    logic [CFG_W-1:0] v;
    if (r < CFG_W'(2)) v = CFG_W'(2);
    else if (int'(r) > GRID_SIDE) v = CFG_W'(GRID_SIDE);
    else v = r;
    return v;
  endfunction

  assign eff_w = eff_size(grid_width_r);
  assign eff_h = eff_size(grid_height_r);

  // table clear after reset
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(DEPTH - 1)) clr_busy_r <= 1'b0;
    end
  end

  // pipeline control
  logic en;
  logic [8:1] v_r;
  logic out_valid_r;
  logic in_acc;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en && !clr_busy_r;
  assign in_acc    = in_tvalid && in_tready;

  // stage 1: register fields, scale the point
  logic              s1_kind_r;
  logic [5:0]        s1_col_r, s1_row_r;
  logic [2*GRAD_W-1:0] s1_grad_r;
  logic [SW-1:0]     s1_sx_r, s1_sy_r;
  pos_t              px_sat, py_sat;

  always_comb begin
    px_sat = in_tdata[60:44];
    py_sat = in_tdata[77:61];
    if (px_sat > ONE_Q) px_sat = ONE_Q;
    if (py_sat > ONE_Q) py_sat = ONE_Q;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind_r <= in_tuser;
      s1_col_r  <= in_tdata[5:0];
      s1_row_r  <= in_tdata[11:6];
      s1_grad_r <= in_tdata[43:12];
      s1_sx_r   <= SW'(px_sat) * SW'(eff_w - CFG_W'(1));
      s1_sy_r   <= SW'(py_sat) * SW'(eff_h - CFG_W'(1));
    end
  end

  // stage 2: split into cell and fraction, table access
  logic [CFG_W:0]  cxr, cyr;
  logic [CFG_W-1:0] cx7, cy7;
  logic [CW-1:0]   cx, cy, cx1, cy1;
  pos_t            tx, ty;
  logic [AW-1:0]   raddr [4];
  logic [AW-1:0]   waddr;
  logic            we, re, wr_hit;
  logic [2*GRAD_W-1:0] wdata;
  logic [2*GRAD_W-1:0] rdata [4];

  always_comb begin
    cxr = s1_sx_r[SW-1:FRAC_BITS];
    cyr = s1_sy_r[SW-1:FRAC_BITS];
    cx7 = cxr[CFG_W-1:0];
    cy7 = cyr[CFG_W-1:0];
    tx  = {1'b0, s1_sx_r[FRAC_BITS-1:0]};
    ty  = {1'b0, s1_sy_r[FRAC_BITS-1:0]};
    // point at one: last cell, fraction one
    if (cxr >= {1'b0, eff_w - CFG_W'(1)}) begin
      cx7 = eff_w - CFG_W'(2);
      tx  = ONE_Q;
    end
    if (cyr >= {1'b0, eff_h - CFG_W'(1)}) begin
      cy7 = eff_h - CFG_W'(2);
      ty  = ONE_Q;
    end
    cx  = CW'(cx7);
    cy  = CW'(cy7);
    cx1 = cx + CW'(1);
    cy1 = cy + CW'(1);
    raddr[0] = AW'(AW'(cy)  * AW'(GRID_SIDE) + AW'(cx));
    raddr[1] = AW'(AW'(cy)  * AW'(GRID_SIDE) + AW'(cx1));
    raddr[2] = AW'(AW'(cy1) * AW'(GRID_SIDE) + AW'(cx1));
    raddr[3] = AW'(AW'(cy1) * AW'(GRID_SIDE) + AW'(cx));
  end

  assign wr_hit = en && v_r[1] && (s1_kind_r == KIND_WRITE)
                  && (int'(s1_col_r) < GRID_SIDE) && (int'(s1_row_r) < GRID_SIDE);
  assign we     = clr_busy_r || wr_hit;
  assign waddr  = clr_busy_r ? clr_addr_r
                : AW'(AW'(s1_row_r) * AW'(GRID_SIDE) + AW'(s1_col_r));
  assign wdata  = clr_busy_r ? '0 : s1_grad_r;
  assign re     = en && v_r[1] && (s1_kind_r == KIND_EVAL);

  for (genvar k = 0; k < 4; k++) begin : g_tab
    gn2d_ram #(.W(2 * GRAD_W), .DEPTH(DEPTH)) u_ram (
      .clk     (clk),
      .we      (we),
      .waddr   (waddr),
      .wdata   (wdata),
      .re      (re),
      .raddr   (raddr[k]),
      .rdata_r (rdata[k])
    );
  end

  pos_t s2_tx_r, s2_ty_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s2_tx_r <= tx;
      s2_ty_r <= ty;
    end
  end

  // stage 3: corner dots; fades start here
  logic signed [OFF_W-1:0] ox0, ox1, oy0, oy1;
  logic signed [OFF_W-1:0] oxs [4];
  logic signed [OFF_W-1:0] oys [4];
  logic signed [DOT_W+13:0] dsum [4];
  dot_t d_nxt [4];
  dot_t d3_r [4], d4_r [4], d5_r [4], d6_r [4], d7_r [4];

  always_comb begin
    ox0 = -$signed({1'b0, s2_tx_r});
    ox1 = $signed({1'b0, ONE_Q}) - $signed({1'b0, s2_tx_r});
    oy0 = -$signed({1'b0, s2_ty_r});
    oy1 = $signed({1'b0, ONE_Q}) - $signed({1'b0, s2_ty_r});
    oxs[0] = ox0; oys[0] = oy0;
    oxs[1] = ox1; oys[1] = oy0;
    oxs[2] = ox1; oys[2] = oy1;
    oxs[3] = ox0; oys[3] = oy1;
    for (int k = 0; k < 4; k++) begin
      dsum[k] = $signed(rdata[k][GRAD_W-1:0]) * oxs[k]
              + $signed(rdata[k][2*GRAD_W-1:GRAD_W]) * oys[k];
      d_nxt[k] = DOT_W'((dsum[k] + (DOT_W+14)'(8192)) >>> 14);
    end
  end

  fade_t fx0, fx1, fy0, fy1;
  gn2d_fade u_fx0 (.clk(clk), .en(en), .t_i(ONE_Q - s2_tx_r), .f_o(fx0));
  gn2d_fade u_fx1 (.clk(clk), .en(en), .t_i(s2_tx_r),         .f_o(fx1));
  gn2d_fade u_fy0 (.clk(clk), .en(en), .t_i(ONE_Q - s2_ty_r), .f_o(fy0));
  gn2d_fade u_fy1 (.clk(clk), .en(en), .t_i(s2_ty_r),         .f_o(fy1));

  // stage 7: corner weights; stage 8: weighted dots
  localparam logic [2*FADE_W-1:0] WHALF = (2*FADE_W)'(1) << (FRAC_BITS - 1);
  logic [WGT_W-1:0] w_nxt [4];
  logic [WGT_W-1:0] w7_r [4];
  logic signed [PROD_W-1:0] p8_r [4];
  fade_t fa [4];
  fade_t fb [4];

  always_comb begin
    fa[0] = fx0; fb[0] = fy0;
    fa[1] = fx1; fb[1] = fy0;
    fa[2] = fx1; fb[2] = fy1;
    fa[3] = fx0; fb[3] = fy1;
    for (int k = 0; k < 4; k++) begin
      w_nxt[k] = WGT_W'(((2*FADE_W)'(fa[k]) * (2*FADE_W)'(fb[k]) + WHALF) >> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        d3_r[k] <= d_nxt[k];
        d4_r[k] <= d3_r[k];
        d5_r[k] <= d4_r[k];
        d6_r[k] <= d5_r[k];
        d7_r[k] <= d6_r[k];
        w7_r[k] <= w_nxt[k];
        p8_r[k] <= $signed({1'b0, w7_r[k]}) * d7_r[k];
      end
    end
  end

  // stage 9: (sum + 1) / 2, clamp
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] res;
  logic [POS_W-1:0] res_q;
  logic [POS_W-1:0] noise_r;

  always_comb begin
    acc = ($signed(ACC_W'(1)) <<< (2 * FRAC_BITS)) + p8_r[0] + p8_r[1] + p8_r[2] + p8_r[3];
    res = (acc + ($signed(ACC_W'(1)) <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
    if (res < 0) res_q = '0;
    else if (res > $signed(ACC_W'(ONE_Q))) res_q = ONE_Q;
    else res_q = res[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) noise_r <= res_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r[1]      <= in_acc;
      v_r[2]      <= v_r[1] && (s1_kind_r == KIND_EVAL);
      v_r[8:3]    <= v_r[7:2];
      out_valid_r <= v_r[8];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(noise_r);

  `GN2D_ASSERT_IMP(a_no_take_in_clear, clr_busy_r, !in_tready, "input taken during table clear")
  `GN2D_ASSERT_IMP(a_rd_wr_excl, re, !we, "table read and write in one cycle")
  `GN2D_ASSERT_NXT(a_stall_freeze, !en, $stable(v_r), "pipeline moved while stalled")
  `GN2D_ASSERT_IMP(a_out_range, out_valid_r, noise_r <= ONE_Q, "noise above one")

endmodule
